@@ hw/rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and datapath operation codes of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int unsigned ARENA_BYTES  = 4194304;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned MAX_BLOCKS   = 64;

  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned ADDR_W = 22;
  localparam int unsigned REQ_W  = 23;
  localparam int unsigned USED_W = 23;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_OOM     = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // datapath operations
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_ADV        = 5'd2;
  localparam logic [4:0] OP_TRIV       = 5'd3;
  localparam logic [4:0] OP_FAIL       = 5'd4;
  localparam logic [4:0] OP_UNK        = 5'd5;
  localparam logic [4:0] OP_WHOLE      = 5'd6;
  localparam logic [4:0] OP_CAPS       = 5'd7;
  localparam logic [4:0] OP_CAPF       = 5'd8;
  localparam logic [4:0] OP_MERGE      = 5'd9;
  localparam logic [4:0] OP_SHD_RD     = 5'd10;
  localparam logic [4:0] OP_SHD_WR     = 5'd11;
  localparam logic [4:0] OP_SHU_RD     = 5'd12;
  localparam logic [4:0] OP_SHU_WR     = 5'd13;
  localparam logic [4:0] OP_SPLIT_REM  = 5'd14;
  localparam logic [4:0] OP_SPLIT_HEAD = 5'd15;
  localparam logic [4:0] OP_PUSH       = 5'd16;

  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } ent_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic is_free_op;
    logic hit;
    logic ent_free;
    logic split;
    logic has_next;
    logic merge_done;
    logic shd_last;
    logic shu_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with coalescing over an address-ordered block table.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                      tuser
// s_axis   in   request_size[22:0], release_offset[44:23] action
// m_axis   out  payload_offset[21:0], bytes_in_use[44:22] status[1:0]
//
// One request at a time. The scan reads one table entry per cycle from the
// one-read one-write table memory; a split or merge then moves each later
// entry with a read state and then a write state. The worst case per
// request is a scan to entry i plus the move of the entries behind it.
// Reset leaves one free block covering the arena; no clearing pass.
// A pending result holds the finished request until taken; the next request
// is accepted once the result register has been loaded.
`default_nettype none

module first_fit_heap_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // request_size, release_offset
  input  wire logic        s_axis_tuser_i,  // action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // payload_offset, bytes_in_use
  output logic [1:0]       m_axis_tuser_o   // status
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;
  logic [ffha_pkg::ADDR_W-1:0] out_offset;
  logic [ffha_pkg::USED_W-1:0] out_used;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffha_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_action_i  (s_axis_tuser_i),
    .in_size_i    (s_axis_tdata_i[22:0]),
    .in_offset_i  (s_axis_tdata_i[44:23]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_offset_o (out_offset),
    .out_used_o   (out_used)
  );

  assign m_axis_tdata_o = {3'b000, out_used, out_offset};

endmodule

`default_nettype wire

@@ hw/rtl/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: table scan, entry shifting for split and merge, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire ffha_pkg::sts_t sts_i,
  output ffha_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_MERGE  = 4'd2;
  localparam logic [3:0] S_SHD_RD = 4'd3;
  localparam logic [3:0] S_SHD_WR = 4'd4;
  localparam logic [3:0] S_SHU_RD = 4'd5;
  localparam logic [3:0] S_SHU_WR = 4'd6;
  localparam logic [3:0] S_SPL_R  = 4'd7;
  localparam logic [3:0] S_SPL_H  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = ffha_pkg::OP_NONE;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = ffha_pkg::OP_LOAD;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.trivial) begin
          cmd_o.op = ffha_pkg::OP_TRIV;
          state_d  = S_FIN;
        end else if (sts_i.hit) begin
          if (sts_i.is_free_op) begin
            if (sts_i.ent_free) begin
              cmd_o.op = ffha_pkg::OP_UNK;
              state_d  = S_FIN;
            end else begin
              cmd_o.op = ffha_pkg::OP_CAPF;
              state_d  = S_MERGE;
            end
          end else if (sts_i.split) begin
            cmd_o.op = ffha_pkg::OP_CAPS;
            state_d  = sts_i.has_next ? S_SHU_RD : S_SPL_R;
          end else begin
            cmd_o.op = ffha_pkg::OP_WHOLE;
            state_d  = S_FIN;
          end
        end else if (!sts_i.has_next) begin
          cmd_o.op = ffha_pkg::OP_FAIL;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = ffha_pkg::OP_ADV;
        end
      end
      S_MERGE: begin
        cmd_o.op = ffha_pkg::OP_MERGE;
        state_d  = sts_i.merge_done ? S_FIN : S_SHD_RD;
      end
      S_SHD_RD: begin
        cmd_o.op = ffha_pkg::OP_SHD_RD;
        state_d  = S_SHD_WR;
      end
      S_SHD_WR: begin
        cmd_o.op = ffha_pkg::OP_SHD_WR;
        state_d  = sts_i.shd_last ? S_FIN : S_SHD_RD;
      end
      S_SHU_RD: begin
        cmd_o.op = ffha_pkg::OP_SHU_RD;
        state_d  = S_SHU_WR;
      end
      S_SHU_WR: begin
        cmd_o.op = ffha_pkg::OP_SHU_WR;
        state_d  = sts_i.shu_last ? S_SPL_R : S_SHU_RD;
      end
      S_SPL_R: begin
        cmd_o.op = ffha_pkg::OP_SPLIT_REM;
        state_d  = S_SPL_H;
      end
      S_SPL_H: begin
        cmd_o.op = ffha_pkg::OP_SPLIT_HEAD;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = ffha_pkg::OP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ffha_datapath.sv @@
// ----------------------------------------------------------------------------
// ffha_datapath
// Block table memory, item registers, fit/match logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ffha_pkg::cmd_t                  cmd_i,
  output ffha_pkg::sts_t                       sts_o,
  input  wire logic                            in_action_i,
  input  wire logic [ffha_pkg::REQ_W-1:0]      in_size_i,
  input  wire logic [ffha_pkg::ADDR_W-1:0]     in_offset_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           out_status_o,
  output logic [ffha_pkg::ADDR_W-1:0]          out_offset_o,
  output logic [ffha_pkg::USED_W-1:0]          out_used_o
);

  localparam int unsigned AW = ffha_pkg::ADDR_W;
  localparam int unsigned CW = ffha_pkg::CNT_W;
  localparam int unsigned IW = ffha_pkg::IDX_W;
  localparam int unsigned RW = ffha_pkg::REQ_W + 1;
  localparam int unsigned UW = ffha_pkg::USED_W;
  localparam logic [RW-1:0] HDR   = RW'(ffha_pkg::HEADER_BYTES);
  localparam logic [CW-1:0] MAXB  = CW'(ffha_pkg::MAX_BLOCKS);
  localparam logic [CW-1:0] ONE   = CW'(1);
  localparam ffha_pkg::ent_t RESET_ENT = '{free: 1'b1,
    size: AW'(ffha_pkg::ARENA_BYTES - ffha_pkg::HEADER_BYTES), start: '0};

  ffha_pkg::ent_t mem_q [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::ent_t rdata_q, ent, cur_q, prev_q, wdata;
  logic           rinit_q, init_q;
  logic           we;
  logic [CW-1:0]  raddr, waddr;

  logic           op_free_q;
  logic [RW-1:0]  req_q;
  logic [AW-1:0]  off_q;
  logic [CW-1:0]  idx_q, cnt_q, src_q, dst_q;
  logic [UW-1:0]  used_q;
  logic [1:0]     res_sts_q;
  logic [AW-1:0]  res_off_q;
  logic           out_valid_q;

  // merge and split terms
  logic           pf, nf;
  logic [1:0]     rm;
  logic [CW-1:0]  tgt, new_cnt;
  logic [RW-1:0]  msize, rem_size;

  assign ent = rinit_q ? RESET_ENT : rdata_q;

  always_comb begin
    pf       = (idx_q != '0) && prev_q.free;
    nf       = sts_o.has_next && ent.free;
    rm       = {1'b0, pf} + {1'b0, nf};
    tgt      = pf ? idx_q - ONE : idx_q;
    new_cnt  = cnt_q - CW'(rm);
    msize    = RW'(cur_q.size)
             + (pf ? RW'(prev_q.size) + HDR : '0)
             + (nf ? RW'(ent.size) + HDR : '0);
    rem_size = RW'(cur_q.size) - req_q - HDR;
  end

  always_comb begin
    sts_o.trivial    = op_free_q ? (off_q == '0) : (req_q == '0);
    sts_o.is_free_op = op_free_q;
    sts_o.hit        = op_free_q ? (RW'(ent.start) + HDR == RW'(off_q))
                                 : (ent.free && RW'(ent.size) >= req_q);
    sts_o.ent_free   = ent.free;
    sts_o.split      = (RW'(ent.size) >= req_q + HDR + RW'(8)) && (cnt_q < MAXB);
    sts_o.has_next   = (idx_q + ONE) < cnt_q;
    sts_o.merge_done = (tgt + ONE) >= new_cnt;
    sts_o.shd_last   = (dst_q + ONE) == cnt_q;
    sts_o.shu_last   = src_q == (idx_q + ONE);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = idx_q;
    wdata = ent;
    case (cmd_i.op)
      ffha_pkg::OP_ADV:    raddr = idx_q + ONE;
      ffha_pkg::OP_CAPF:   raddr = idx_q + ONE;
      ffha_pkg::OP_SHD_RD: raddr = src_q;
      ffha_pkg::OP_SHU_RD: raddr = src_q;
      ffha_pkg::OP_WHOLE: begin
        we         = 1'b1;
        wdata.free = 1'b0;
      end
      ffha_pkg::OP_MERGE: begin
        we    = 1'b1;
        waddr = tgt;
        wdata = '{free: 1'b1, size: msize[AW-1:0],
                  start: pf ? prev_q.start : cur_q.start};
      end
      ffha_pkg::OP_SHD_WR: begin
        we    = 1'b1;
        waddr = dst_q;
        wdata = rdata_q;
      end
      ffha_pkg::OP_SHU_WR: begin
        we    = 1'b1;
        waddr = src_q + ONE;
        wdata = rdata_q;
      end
      ffha_pkg::OP_SPLIT_REM: begin
        we    = 1'b1;
        waddr = idx_q + ONE;
        wdata = '{free: 1'b1, size: rem_size[AW-1:0],
                  start: AW'(RW'(cur_q.start) + HDR + req_q)};
      end
      ffha_pkg::OP_SPLIT_HEAD: begin
        we    = 1'b1;
        wdata = '{free: 1'b0, size: req_q[AW-1:0], start: cur_q.start};
      end
      default: ;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr[IW-1:0]] <= wdata;
    end
    rdata_q <= mem_q[raddr[IW-1:0]];
  end

  // entry 0 reads as its reset value until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= 1'b1;
      rinit_q <= 1'b0;
    end else begin
      rinit_q <= init_q && (raddr[IW-1:0] == '0);
      if (we && waddr[IW-1:0] == '0) begin
        init_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= ONE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == ffha_pkg::OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        ffha_pkg::OP_WHOLE:
          used_q <= UW'(RW'(used_q) + RW'(ent.size) + HDR);
        ffha_pkg::OP_MERGE: begin
          used_q <= UW'(RW'(used_q) - RW'(cur_q.size) - HDR);
          cnt_q  <= new_cnt;
        end
        ffha_pkg::OP_SPLIT_HEAD: begin
          used_q <= UW'(RW'(used_q) + req_q + HDR);
          cnt_q  <= cnt_q + ONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ffha_pkg::OP_LOAD: begin
        op_free_q <= in_action_i;
        req_q     <= (RW'(in_size_i) + RW'(7)) & ~RW'(7);
        off_q     <= in_offset_i;
        idx_q     <= '0;
      end
      ffha_pkg::OP_ADV: begin
        prev_q <= ent;
        idx_q  <= idx_q + ONE;
      end
      ffha_pkg::OP_TRIV: begin
        res_sts_q <= op_free_q ? ffha_pkg::ST_DONE : ffha_pkg::ST_NULL;
        res_off_q <= '0;
      end
      ffha_pkg::OP_FAIL: begin
        res_sts_q <= op_free_q ? ffha_pkg::ST_UNKNOWN : ffha_pkg::ST_OOM;
        res_off_q <= '0;
      end
      ffha_pkg::OP_UNK: begin
        res_sts_q <= ffha_pkg::ST_UNKNOWN;
        res_off_q <= '0;
      end
      ffha_pkg::OP_WHOLE: begin
        res_sts_q <= ffha_pkg::ST_DONE;
        res_off_q <= AW'(RW'(ent.start) + HDR);
      end
      ffha_pkg::OP_CAPS: begin
        cur_q <= ent;
        src_q <= cnt_q - ONE;
      end
      ffha_pkg::OP_CAPF: cur_q <= ent;
      ffha_pkg::OP_MERGE: begin
        src_q     <= tgt + ONE + CW'(rm);
        dst_q     <= tgt + ONE;
        res_sts_q <= ffha_pkg::ST_DONE;
        res_off_q <= '0;
      end
      ffha_pkg::OP_SHD_WR: begin
        src_q <= src_q + ONE;
        dst_q <= dst_q + ONE;
      end
      ffha_pkg::OP_SHU_WR: src_q <= src_q - ONE;
      ffha_pkg::OP_SPLIT_HEAD: begin
        res_sts_q <= ffha_pkg::ST_DONE;
        res_off_q <= AW'(RW'(cur_q.start) + HDR);
      end
      ffha_pkg::OP_PUSH: begin
        out_status_o <= res_sts_q;
        out_offset_o <= res_off_q;
        out_used_o   <= used_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= MAXB) else $error("block count out of range");
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RW'(used_q) <= RW'(ffha_pkg::ARENA_BYTES)) else $error("bytes in use exceed arena");
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> waddr < MAXB) else $error("table write beyond depth");
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == ffha_pkg::OP_PUSH |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");
`endif

endmodule

`default_nettype wire
